FILE: rtl/npc_pkg.sv
// package for the narrow phase contact unit: types, constants, helpers
`default_nettype none
package npc_pkg;

  localparam int COORD_FRAC_BITS_DEF  = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int NORM_MAX             = 32767;
  localparam logic [30:0] PEN_MAX     = 31'h7fff_ffff;
  localparam int QUEUE_DEPTH          = 4;

  typedef enum logic [1:0] {
    FUNC_CIRCLE_CIRCLE = 2'd0,
    FUNC_CIRCLE_GROUND = 2'd1,
    FUNC_CIRCLE_BOX    = 2'd2,
    FUNC_BOX_BOX       = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    REG_GROUND_LEVEL      = 1'b0,
    REG_CONTACT_THRESHOLD = 1'b1
  } reg_idx_t;

  // classified job handed from the front to the back
  typedef struct packed {
    logic        need_dist;   // distance from dx, dy decides the result
    logic        circ;        // circle-circle (else circle-box)
    logic [33:0] dx;          // signed difference
    logic [33:0] dy;
    logic [34:0] base;        // signed: ra+rb or ra
    logic [16:0] thr;         // circle-circle threshold
    logic        hit;         // direct result for ground and box-box
    logic [15:0] nx;
    logic [15:0] ny;
    logic [30:0] pen;
  } job_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [30:0] pen;
  } res_t;

  function automatic logic [30:0] sat_pen(input logic signed [35:0] p);
    logic [30:0] r;
    if (p < 0) r = '0;
    else if (p > 36'sd2147483647) r = PEN_MAX;
    else r = p[30:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/npc_front.sv
// front part: classifies a body pair and settles the simple tests
`default_nettype none
module npc_front #(
  parameter int NORMAL_FRAC_BITS = npc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] a_x,
  input  wire logic signed [31:0] a_y,
  input  wire logic [29:0]        a_ex,
  input  wire logic [29:0]        a_ey,
  input  wire logic signed [31:0] b_x,
  input  wire logic signed [31:0] b_y,
  input  wire logic [29:0]        b_ex,
  input  wire logic [29:0]        b_ey,
  input  wire logic signed [31:0] ground_level,
  input  wire logic [15:0]        contact_threshold,
  output npc_pkg::job_t           job
);
  localparam logic [15:0] UNIT = ((1 << NORMAL_FRAC_BITS) > npc_pkg::NORM_MAX) ?
      16'(npc_pkg::NORM_MAX) : 16'(1 << NORMAL_FRAC_BITS);

  logic signed [33:0] lox, hix, loy, hiy, px, py, ax, ay, bx, by;
  logic signed [33:0] low, gl, ox, oy, adx, ady;

  always_comb begin
    ax = 34'(a_x); ay = 34'(a_y); bx = 34'(b_x); by = 34'(b_y);
    gl = 34'(ground_level);
    lox = bx - 34'(b_ex); hix = bx + 34'(b_ex);
    loy = by - 34'(b_ey); hiy = by + 34'(b_ey);
    px = ax; py = ay;
    if (px < lox) px = lox;
    if (px > hix) px = hix;
    if (py < loy) py = loy;
    if (py > hiy) py = hiy;
    low = ay - 34'(a_ex);
    adx = (ax < bx) ? bx - ax : ax - bx;
    ady = (ay < by) ? by - ay : ay - by;
    ox = 34'(a_ex) + 34'(b_ex) - adx;
    oy = 34'(a_ey) + 34'(b_ey) - ady;

    job = '0;
    job.thr = {1'b0, contact_threshold};
    unique case (npc_pkg::func_t'(func))
      npc_pkg::FUNC_CIRCLE_CIRCLE: begin
        job.need_dist = 1'b1;
        job.circ = 1'b1;
        job.dx = bx - ax;
        job.dy = by - ay;
        job.base = 35'(a_ex) + 35'(b_ex);
      end
      npc_pkg::FUNC_CIRCLE_BOX: begin
        job.need_dist = 1'b1;
        job.dx = px - ax;
        job.dy = py - ay;
        job.base = 35'(a_ex);
      end
      npc_pkg::FUNC_CIRCLE_GROUND: begin
        if (low <= gl) begin
          job.hit = 1'b1;
          job.ny = UNIT;
          job.pen = npc_pkg::sat_pen(36'(gl - low));
        end
      end
      default: begin
        if (ox > 0 && oy > 0) begin
          job.hit = 1'b1;
          if (ox < oy) begin
            job.nx = (ax < bx) ? UNIT : 16'(-UNIT);
            job.pen = npc_pkg::sat_pen(36'(ox));
          end else begin
            job.ny = (ay < by) ? UNIT : 16'(-UNIT);
            job.pen = npc_pkg::sat_pen(36'(oy));
          end
        end
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/npc_queue.sv
// short queue between front and back
`default_nettype none
module npc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = npc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output      logic             wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output      logic             rd_valid,
  input  wire logic             rd_ready,
  output      logic [WIDTH-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count");
  a_empty_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !rd_valid) else $error("queue empty valid");
endmodule
`default_nettype wire

FILE: rtl/npc_back.sv
// back part: pipelined distance, square root and normal division
`default_nettype none
module npc_back #(
  parameter int COORD_FRAC_BITS  = npc_pkg::COORD_FRAC_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = npc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire npc_pkg::job_t in_job,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output npc_pkg::res_t      out_res
);
  // sqrt: 32 stages, one result bit each; divide: NQ stages
  localparam int SQ  = 32;
  localparam int NQ  = NORMAL_FRAC_BITS + 2;           // quotient bits up to 2^(N+1)
  localparam int NS  = 2 + SQ + 1 + NQ + 1;            // total stages
  localparam logic [6:0] EPS = 7'((((1 << COORD_FRAC_BITS) + 999999) / 1000000));
  localparam logic [15:0] UNIT = ((1 << NORMAL_FRAC_BITS) > npc_pkg::NORM_MAX) ?
      16'(npc_pkg::NORM_MAX) : 16'(1 << NORMAL_FRAC_BITS);
  localparam int DW = 31 + NORMAL_FRAC_BITS + 1;       // dividend width

  typedef struct packed {
    npc_pkg::job_t j;
    logic          nxn, nyn;
    logic [1:0]    s;
    logic [30:0]   mx, my;
    logic [63:0]   sum;       // radicand remainder
    logic [31:0]   root;
    logic [35:0]   span;      // full-scale distance
    logic [DW-1:0] remx, remy;
    logic [DW-1:0] qx, qy;
  } st_t;

  st_t st_r [NS];
  logic [NS-1:0] v_r;
  logic adv;

  // whole pipe moves together; stalls only when the output stage is held
  assign adv = !v_r[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[NS-1];

  st_t s0, s1;
  logic [33:0] ax, ay;
  always_comb begin
    s0 = '0;
    s0.j = in_job;
    s0.nxn = in_job.dx[33];
    s0.nyn = in_job.dy[33];
    ax = in_job.dx[33] ? -in_job.dx : in_job.dx;
    ay = in_job.dy[33] ? -in_job.dy : in_job.dy;
    // smallest shift bringing both below 2^31 (magnitudes < 2^34)
    if (ax[33] || ay[33]) s0.s = 2'd3;
    else if (ax[32] || ay[32]) s0.s = 2'd2;
    else if (ax[31] || ay[31]) s0.s = 2'd1;
    else s0.s = 2'd0;
    s0.mx = 31'(ax >> s0.s);
    s0.my = 31'(ay >> s0.s);
  end

  // stage 1: squares (two 31x31 multipliers), stage 2 add
  logic [61:0] sqx_r, sqy_r;
  st_t p1_r;

  always_comb begin
    s1 = p1_r;
    s1.sum = 64'(sqx_r) + 64'(sqy_r);
    s1.root = '0;
  end

  // sqrt step on stage k: remainder in sum, root grows by one bit
  function automatic st_t sq_step(input st_t a, input int k);
    st_t b;
    logic [63:0] trial;
    logic [63:0] bitv;
    b = a;
    bitv = 64'(1) << (2 * (31 - k));
    trial = (64'(a.root) << (32 - k)) + bitv;
    if (a.sum >= trial) begin
      b.sum = a.sum - trial;
      b.root = a.root | (32'(1) << (31 - k));
    end
    return b;
  endfunction

  function automatic st_t div_step(input st_t a, input int k);
    st_t b;
    logic [DW+31:0] dvx, dvy;
    b = a;
    dvx = (DW+32)'(a.root) << (NQ - 1 - k);
    dvy = dvx;
    if ((DW+32)'(a.remx) >= dvx) begin
      b.remx = a.remx - DW'(dvx);
      b.qx[NQ-1-k] = 1'b1;
    end
    if ((DW+32)'(a.remy) >= dvy) begin
      b.remy = a.remy - DW'(dvy);
      b.qy[NQ-1-k] = 1'b1;
    end
    return b;
  endfunction

  // prepare division: dividend = m*2^N + ds/2
  function automatic st_t div_prep(input st_t a);
    st_t b;
    b = a;
    b.span = 36'(a.root) << a.s;
    b.remx = (DW'(a.mx) << NORMAL_FRAC_BITS) + DW'(a.root >> 1);
    b.remy = (DW'(a.my) << NORMAL_FRAC_BITS) + DW'(a.root >> 1);
    b.qx = '0; b.qy = '0;
    return b;
  endfunction

  function automatic npc_pkg::res_t finish(input st_t a);
    npc_pkg::res_t r;
    logic signed [35:0] p;
    logic [15:0] qx, qy;
    logic hit;
    r.hit = a.j.hit; r.nx = a.j.nx; r.ny = a.j.ny; r.pen = a.j.pen;
    qx = (a.qx > DW'(npc_pkg::NORM_MAX)) ? 16'(npc_pkg::NORM_MAX) : a.qx[15:0];
    qy = (a.qy > DW'(npc_pkg::NORM_MAX)) ? 16'(npc_pkg::NORM_MAX) : a.qy[15:0];
    if (a.root == '0) begin qx = '0; qy = '0; end
    if (a.j.need_dist) begin
      p = 36'(signed'(a.j.base)) - signed'(a.span);
      if (a.j.circ) hit = p > signed'(36'(a.j.thr));
      else hit = signed'(a.span) < 36'(signed'(a.j.base));
      r.hit = hit;
      r.nx = '0; r.ny = '0; r.pen = '0;
      if (hit) begin
        r.pen = npc_pkg::sat_pen(p);
        if (!a.j.circ && a.span < 36'(EPS)) begin
          r.ny = UNIT;
        end else begin
          r.nx = a.nxn ? 16'(-qx) : qx;
          r.ny = a.nyn ? 16'(-qy) : qy;
        end
      end
    end
    return r;
  endfunction

  npc_pkg::res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= s0;
      p1_r <= s0;
      sqx_r <= s0.mx * s0.mx;
      sqy_r <= s0.my * s0.my;
      st_r[1] <= s1;
      for (int k = 0; k < SQ; k++) st_r[2+k] <= sq_step(st_r[1+k], k);
      st_r[2+SQ] <= div_prep(st_r[1+SQ]);
      for (int k = 0; k < NQ; k++) st_r[3+SQ+k] <= div_step(st_r[2+SQ+k], k);
      st_r[NS-1] <= st_r[NS-2];
      res_r <= finish(st_r[NS-2]);
    end
  end

  assign out_res = res_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_res)) else $error("result lost");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.hit) |-> (out_res.pen == '0 && out_res.nx == '0))
    else $error("miss not zero");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv) |-> in_ready == 1'b0) else $error("stall flow");
endmodule
`default_nettype wire

FILE: rtl/narrow_phase_contact_unit.sv
// top level of the narrow phase contact unit
// Tests one pair of 2D bodies per transfer (circle-circle, circle-ground,
// circle-box, box-box) and returns one result per pair. A new pair can be
// taken every cycle while in_tready is high. The front classifies the pair
// in one combinational step and pushes a job into a 4-entry queue; the back
// is a fixed pipeline of squares, a 32-stage square root and a
// NORMAL_FRAC_BITS+2 stage restoring divider. The whole back pipeline
// advances together and holds only while its last result waits on
// out_tready; the queue then fills and in_tready drops. Configuration
// writes take effect on the next pair.
`default_nettype none
module narrow_phase_contact_unit #(
  parameter int COORD_FRAC_BITS  = npc_pkg::COORD_FRAC_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = npc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // tdata: a_x, a_y, a_extent_x, a_extent_y, b_x, b_y, b_extent_x, b_extent_y
  input  wire logic [247:0] in_tdata,
  input  wire logic [1:0]   in_tuser,   // func
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // tdata: hit, normal_x, normal_y, penetration
  output      logic [63:0]  out_tdata
);
  logic signed [31:0] ground_level_r;
  logic [15:0] contact_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_level_r <= '0;
      contact_threshold_r <= 16'd66;
    end else if (cfg_we) begin
      unique case (npc_pkg::reg_idx_t'(cfg_index))
        npc_pkg::REG_GROUND_LEVEL:      ground_level_r <= cfg_wdata;
        npc_pkg::REG_CONTACT_THRESHOLD: contact_threshold_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  npc_pkg::job_t job, qjob;
  logic q_valid, q_ready;
  npc_pkg::res_t res;

  npc_front #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_front (
    .func(in_tuser),
    .a_x(in_tdata[31:0]), .a_y(in_tdata[63:32]),
    .a_ex(in_tdata[93:64]), .a_ey(in_tdata[123:94]),
    .b_x(in_tdata[155:124]), .b_y(in_tdata[187:156]),
    .b_ex(in_tdata[217:188]), .b_ey(in_tdata[247:218]),
    .ground_level(ground_level_r), .contact_threshold(contact_threshold_r),
    .job
  );

  npc_queue #(.WIDTH($bits(npc_pkg::job_t))) u_queue (
    .clk, .rst_n,
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(qjob)
  );

  npc_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS))
    u_back (
    .clk, .rst_n,
    .in_valid(q_valid), .in_ready(q_ready), .in_job(qjob),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {res.pen, res.ny, res.nx, res.hit};

  a_cfg_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == npc_pkg::REG_CONTACT_THRESHOLD)
    |=> contact_threshold_r == $past(cfg_wdata[15:0]))
    else $error("threshold write");
  a_cfg_gl: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == npc_pkg::REG_GROUND_LEVEL) |=> ground_level_r == $past(cfg_wdata))
    else $error("ground write");
  // a miss carries no normal and no depth
  a_out_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> out_tdata[63:1] == '0) else $error("miss fields");
endmodule
`default_nettype wire
